FILE: rtl/tqts_pkg.sv
// Shared types, sizes and helpers for the task queue and timer slot engine.
// Used by every module of the block; depends on nothing else.
package tqts_pkg;

    localparam int FIFO_DEPTH  = 32;
    localparam int TIMER_SLOTS = 8;

    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH);
    localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam int HANDLE_W = 32;
    localparam int DELAY_W  = 32;
    localparam int DATA_W   = 64;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_PURGE    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TIMER = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DISP,
        S_PURGE_F,
        S_PURGE_S,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   payload;
        logic [DATA_W-1:0]   stamp;
    } t_fifo_entry;

    // One word of commands from the sequencer to the queue memory.
    typedef struct packed {
        logic               rd_en;
        logic [FIFO_AW-1:0] rd_addr;
        logic               wr_entry;
        logic               wr_handle;
        logic [FIFO_AW-1:0] wr_addr;
    } t_fifo_cmd;

    // Commands from the sequencer to the slot table.
    typedef struct packed {
        logic              fill;
        logic              purge;
        logic [SLOT_W-1:0] idx;
    } t_slot_cmd;

    function automatic logic [FIFO_AW-1:0] fifo_next(input logic [FIFO_AW-1:0] addr);
        logic [FIFO_AW-1:0] res;
        if (addr == FIFO_AW'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = addr + FIFO_AW'(1);
        end
        return res;
    endfunction

endpackage

FILE: rtl/task_queue_and_timer_slot_engine.sv
// Top level of the task queue and timer slot engine: command sequencer and shared comparator.
// Depends on tqts_pkg, tqts_fifo_mem and tqts_slot_table.
//
// A command is taken when start is high while busy is low; busy then stays high until the
// cycle after the result. The result is shown for exactly one cycle with o_done high and
// cannot be held off, so it must be captured when it appears. A schedule, a dispatch on an
// empty queue or the unused operation code passes through the execute and done states, and a
// dispatch that pops a word also passes through a dispatch state for the registered read of
// the queue memory. A purge shares one 32-bit handle comparator, which checks one queued
// entry per cycle, then one timer slot per cycle over all 8 slots. The null handle
// register may be written at any time the block is idle; its port is always ready.
module task_queue_and_timer_slot_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_task_handle,
    input  logic [31:0] i_timer_delay,
    input  logic [63:0] i_task_payload,
    input  logic [63:0] i_current_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_dispatch_valid,
    output logic [31:0] o_out_handle,
    output logic [63:0] o_out_payload,
    output logic [63:0] o_out_stamp,
    output logic [4:0]  o_queued_count
);
    import tqts_pkg::*;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [DATA_W-1:0]   r_payload, n_payload;
    logic [DATA_W-1:0]   r_time, n_time;
    logic [HANDLE_W-1:0] r_null;
    logic [FIFO_AW-1:0]  r_wr_idx, n_wr_idx;
    logic [FIFO_AW-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FIFO_AW-1:0]  r_walk_ptr, n_walk_ptr;
    logic [CNT_W-1:0]    r_walk_cnt, n_walk_cnt;
    logic [SLOT_W-1:0]   r_slot_idx, n_slot_idx;
    t_status             r_status, n_status;
    logic                r_dvalid, n_dvalid;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [DATA_W-1:0]   r_out_payload, n_out_payload;
    logic [DATA_W-1:0]   r_out_stamp, n_out_stamp;

    t_fifo_cmd           fifo_cmd;
    t_fifo_entry         fifo_wr;
    t_fifo_entry         fifo_rd;
    t_slot_cmd           slot_cmd;
    logic                slot_free;
    logic [DELAY_W-1:0]  slot_rd_delay;
    logic [HANDLE_W-1:0] slot_rd_handle;

    logic [HANDLE_W-1:0] cmp_b;
    logic                match;

    tqts_fifo_mem u_fifo (
        .i_clk     (i_clk),
        .i_cmd     (fifo_cmd),
        .i_wr_data (fifo_wr),
        .o_rd_data (fifo_rd)
    );

    tqts_slot_table u_slots (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (slot_cmd),
        .i_fill_delay   (r_delay),
        .i_fill_handle  (r_handle),
        .i_fill_payload (r_payload),
        .i_fill_stamp   (r_time),
        .i_null_handle  (r_null),
        .o_free_found   (slot_free),
        .o_rd_delay     (slot_rd_delay),
        .o_rd_handle    (slot_rd_handle)
    );

    // The one handle comparator serves both the queue walk and the slot walk.
    assign cmp_b = (r_state == S_PURGE_F) ? fifo_rd.handle : slot_rd_handle;
    assign match = (cmp_b == r_handle);

    assign fifo_wr.handle  = fifo_cmd.wr_entry ? r_handle : r_null;
    assign fifo_wr.payload = r_payload;
    assign fifo_wr.stamp   = r_time;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_handle      = r_handle;
        n_delay       = r_delay;
        n_payload     = r_payload;
        n_time        = r_time;
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_count       = r_count;
        n_walk_ptr    = r_walk_ptr;
        n_walk_cnt    = r_walk_cnt;
        n_slot_idx    = r_slot_idx;
        n_status      = r_status;
        n_dvalid      = r_dvalid;
        n_out_handle  = r_out_handle;
        n_out_payload = r_out_payload;
        n_out_stamp   = r_out_stamp;
        fifo_cmd      = '0;
        slot_cmd      = '0;
        slot_cmd.idx  = r_slot_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op          = t_op'(i_operation);
                    n_handle      = i_task_handle;
                    n_delay       = i_timer_delay;
                    n_payload     = i_task_payload;
                    n_time        = i_current_time;
                    n_status      = ST_OK;
                    n_dvalid      = 1'b0;
                    n_out_handle  = '0;
                    n_out_payload = '0;
                    n_out_stamp   = '0;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_SCHEDULE: begin
                        if (r_delay != '0) begin
                            if (slot_free) begin
                                slot_cmd.fill = 1'b1;
                            end else begin
                                n_status = ST_NO_TIMER;
                            end
                        end else if (r_count < CNT_W'(FIFO_DEPTH - 1)) begin
                            fifo_cmd.wr_entry = 1'b1;
                            fifo_cmd.wr_addr  = r_wr_idx;
                            n_wr_idx          = fifo_next(r_wr_idx);
                            n_count           = r_count + CNT_W'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    OP_DISPATCH: begin
                        if (r_count != '0) begin
                            fifo_cmd.rd_en   = 1'b1;
                            fifo_cmd.rd_addr = r_rd_idx;
                            n_state          = S_DISP;
                        end else begin
                            n_status = ST_EMPTY;
                        end
                    end
                    OP_PURGE: begin
                        n_walk_ptr = r_rd_idx;
                        n_walk_cnt = '0;
                        n_slot_idx = '0;
                        if (r_count != '0) begin
                            fifo_cmd.rd_en   = 1'b1;
                            fifo_cmd.rd_addr = r_rd_idx;
                            n_state          = S_PURGE_F;
                        end else begin
                            n_state = S_PURGE_S;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DISP: begin
                n_dvalid      = 1'b1;
                n_out_handle  = fifo_rd.handle;
                n_out_payload = fifo_rd.payload;
                n_out_stamp   = fifo_rd.stamp;
                n_rd_idx      = fifo_next(r_rd_idx);
                n_count       = r_count - CNT_W'(1);
                n_state       = S_DONE;
            end
            S_PURGE_F: begin
                // The entry read last cycle is checked while the next one is fetched.
                if (match) begin
                    fifo_cmd.wr_handle = 1'b1;
                    fifo_cmd.wr_addr   = r_walk_ptr;
                end
                if (({1'b0, r_walk_cnt} + (CNT_W + 1)'(1)) < {1'b0, r_count}) begin
                    n_walk_cnt       = r_walk_cnt + CNT_W'(1);
                    n_walk_ptr       = fifo_next(r_walk_ptr);
                    fifo_cmd.rd_en   = 1'b1;
                    fifo_cmd.rd_addr = fifo_next(r_walk_ptr);
                end else begin
                    n_state = S_PURGE_S;
                end
            end
            S_PURGE_S: begin
                if ((slot_rd_delay != '0) && match) begin
                    slot_cmd.purge = 1'b1;
                end
                if (r_slot_idx == SLOT_W'(TIMER_SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_slot_idx = r_slot_idx + SLOT_W'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_null     <= '0;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_count    <= '0;
            r_walk_ptr <= '0;
            r_walk_cnt <= '0;
            r_slot_idx <= '0;
            r_op       <= OP_NONE;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_count    <= n_count;
            r_walk_ptr <= n_walk_ptr;
            r_walk_cnt <= n_walk_cnt;
            r_slot_idx <= n_slot_idx;
            r_op       <= n_op;
            if (i_cfg_valid && o_cfg_ready) begin
                r_null <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle      <= n_handle;
        r_delay       <= n_delay;
        r_payload     <= n_payload;
        r_time        <= n_time;
        r_status      <= n_status;
        r_dvalid      <= n_dvalid;
        r_out_handle  <= n_out_handle;
        r_out_payload <= n_out_payload;
        r_out_stamp   <= n_out_stamp;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_done           = (r_state == S_DONE);
    assign o_status         = r_status;
    assign o_dispatch_valid = r_dvalid;
    assign o_out_handle     = r_out_handle;
    assign o_out_payload    = r_out_payload;
    assign o_out_stamp      = r_out_stamp;
    assign o_queued_count   = 5'(r_count);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block did not go busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH - 1))
        else $error("queue count beyond its limit");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dispatch_valid) |-> (r_status == ST_OK && r_op == OP_DISPATCH))
        else $error("dispatched word with a bad status or operation");

    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("dispatch did not pop exactly one word");

endmodule

FILE: rtl/tqts_fifo_mem.sv
// Task queue storage: handle, payload and stamp arrays with one write and one read port.
// Read data is registered. Depends on tqts_pkg.
module tqts_fifo_mem (
    input  logic                 i_clk,
    input  tqts_pkg::t_fifo_cmd  i_cmd,
    input  tqts_pkg::t_fifo_entry i_wr_data,
    output tqts_pkg::t_fifo_entry o_rd_data
);
    import tqts_pkg::*;

    logic [HANDLE_W-1:0] r_handles  [FIFO_DEPTH];
    logic [DATA_W-1:0]   r_payloads [FIFO_DEPTH];
    logic [DATA_W-1:0]   r_stamps   [FIFO_DEPTH];
    t_fifo_entry         r_rd_data;

    // A purge rewrites only the handle of an entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry || i_cmd.wr_handle) begin
            r_handles[i_cmd.wr_addr] <= i_wr_data.handle;
        end
        if (i_cmd.wr_entry) begin
            r_payloads[i_cmd.wr_addr] <= i_wr_data.payload;
            r_stamps[i_cmd.wr_addr]   <= i_wr_data.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data.handle  <= r_handles[i_cmd.rd_addr];
            r_rd_data.payload <= r_payloads[i_cmd.rd_addr];
            r_rd_data.stamp   <= r_stamps[i_cmd.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/tqts_slot_table.sv
// Timer slot table: delay, handle, payload and stamp per slot, with a first-free search.
// Depends on tqts_pkg.
module tqts_slot_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tqts_pkg::t_slot_cmd        i_cmd,
    input  logic [31:0]                i_fill_delay,
    input  logic [31:0]                i_fill_handle,
    input  logic [63:0]                i_fill_payload,
    input  logic [63:0]                i_fill_stamp,
    input  logic [31:0]                i_null_handle,
    output logic                       o_free_found,
    output logic [31:0]                o_rd_delay,
    output logic [31:0]                o_rd_handle
);
    import tqts_pkg::*;

    logic [DELAY_W-1:0]  r_delay   [TIMER_SLOTS];
    logic [HANDLE_W-1:0] r_handle  [TIMER_SLOTS];
    logic [DATA_W-1:0]   r_payload [TIMER_SLOTS];
    logic [DATA_W-1:0]   r_stamp   [TIMER_SLOTS];

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    // Scan from the top down so the lowest free slot wins.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
            if (r_delay[s] == '0) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                r_delay[s]   <= '0;
                r_handle[s]  <= '0;
                r_payload[s] <= '0;
                r_stamp[s]   <= '0;
            end
        end else if (i_cmd.fill && free_found) begin
            r_delay[free_idx]   <= i_fill_delay;
            r_handle[free_idx]  <= i_fill_handle;
            r_payload[free_idx] <= i_fill_payload;
            r_stamp[free_idx]   <= i_fill_stamp;
        end else if (i_cmd.purge) begin
            r_delay[i_cmd.idx]  <= '0;
            r_handle[i_cmd.idx] <= i_null_handle;
        end
    end

    assign o_free_found = free_found;
    assign o_rd_delay   = r_delay[i_cmd.idx];
    assign o_rd_handle  = r_handle[i_cmd.idx];

endmodule

FILE: verif/tb.sv
// Testbench for the task queue and timer slot engine: directed and random commands are
// checked against a scoreboard that predicts status, dispatched task and queue count.
// Depends on tqts_pkg and task_queue_and_timer_slot_engine.
`timescale 1ns / 1ps

module tb;
    import tqts_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TARGET_WORDS = 1650;
    localparam int REPORT_MAX   = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_operation;
    logic [HANDLE_W-1:0] i_task_handle;
    logic [DELAY_W-1:0]  i_timer_delay;
    logic [DATA_W-1:0]   i_task_payload;
    logic [DATA_W-1:0]   i_current_time;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [HANDLE_W-1:0] i_cfg_data;
    logic                o_done;
    logic [1:0]          o_status;
    logic                o_dispatch_valid;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [DATA_W-1:0]   o_out_payload;
    logic [DATA_W-1:0]   o_out_stamp;
    logic [4:0]          o_queued_count;

    typedef struct {
        t_status             status;
        logic                dispatched;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   payload;
        logic [DATA_W-1:0]   stamp;
        logic [CNT_W-1:0]    count;
    } t_task_result;

    // Predicts the engine's answer to every accepted command and checks the answers.
    class task_queue_scoreboard;
        logic [HANDLE_W-1:0] null_handle;
        logic [HANDLE_W-1:0] q_handle  [FIFO_DEPTH];
        logic [DATA_W-1:0]   q_payload [FIFO_DEPTH];
        logic [DATA_W-1:0]   q_stamp   [FIFO_DEPTH];
        int                  rd_ptr;
        int                  wr_ptr;
        int                  depth_used;
        logic [DELAY_W-1:0]  slot_delay   [TIMER_SLOTS];
        logic [HANDLE_W-1:0] slot_handle  [TIMER_SLOTS];
        logic [DATA_W-1:0]   slot_payload [TIMER_SLOTS];
        logic [DATA_W-1:0]   slot_stamp   [TIMER_SLOTS];
        t_task_result        awaited[$];
        int unsigned         mismatches;

        function new();
            null_handle = '0;
            rd_ptr      = 0;
            wr_ptr      = 0;
            depth_used  = 0;
            mismatches  = 0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                slot_delay[i]   = '0;
                slot_handle[i]  = '0;
                slot_payload[i] = '0;
                slot_stamp[i]   = '0;
            end
        endfunction

        function void set_null_handle(logic [HANDLE_W-1:0] value);
            null_handle = value;
        endfunction

        function int wrap_next(int idx);
            return (idx == FIFO_DEPTH - 1) ? 0 : idx + 1;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_command(t_op op, logic [HANDLE_W-1:0] handle,
                                   logic [DELAY_W-1:0] delay, logic [DATA_W-1:0] payload,
                                   logic [DATA_W-1:0] now);
            t_task_result r;
            bit           placed;
            int           p;
            r.status     = ST_OK;
            r.dispatched = 1'b0;
            r.handle     = '0;
            r.payload    = '0;
            r.stamp      = '0;
            case (op)
                OP_SCHEDULE: begin
                    if (delay != '0) begin
                        placed = 0;
                        for (int i = 0; i < TIMER_SLOTS; i++) begin
                            if (!placed && slot_delay[i] == '0) begin
                                slot_delay[i]   = delay;
                                slot_handle[i]  = handle;
                                slot_payload[i] = payload;
                                slot_stamp[i]   = now;
                                placed = 1;
                            end
                        end
                        if (!placed) r.status = ST_NO_TIMER;
                    end else if (depth_used < FIFO_DEPTH - 1) begin
                        q_handle[wr_ptr]  = handle;
                        q_payload[wr_ptr] = payload;
                        q_stamp[wr_ptr]   = now;
                        wr_ptr = wrap_next(wr_ptr);
                        depth_used++;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                OP_DISPATCH: begin
                    if (depth_used > 0) begin
                        r.dispatched = 1'b1;
                        r.handle     = q_handle[rd_ptr];
                        r.payload    = q_payload[rd_ptr];
                        r.stamp      = q_stamp[rd_ptr];
                        rd_ptr = wrap_next(rd_ptr);
                        depth_used--;
                    end else begin
                        r.status = ST_EMPTY;
                    end
                end
                OP_PURGE: begin
                    // Only entries still waiting in the queue are compared.
                    p = rd_ptr;
                    for (int i = 0; i < depth_used; i++) begin
                        if (q_handle[p] == handle) q_handle[p] = null_handle;
                        p = wrap_next(p);
                    end
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (slot_delay[i] != '0 && slot_handle[i] == handle) begin
                            slot_delay[i]  = '0;
                            slot_handle[i] = null_handle;
                        end
                    end
                end
                default: ;
            endcase
            r.count = CNT_W'(depth_used);
            awaited.push_back(r);
        endfunction

        function void check_result(t_task_result got);
            t_task_result want;
            bit           bad;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result word with nothing awaited: status %0d count %0d",
                             $realtime, got.status, got.count);
                return;
            end
            want = awaited.pop_front();
            bad = (got.status !== want.status) || (got.dispatched !== want.dispatched) ||
                  (got.handle !== want.handle) || (got.payload !== want.payload) ||
                  (got.stamp !== want.stamp) || (got.count !== want.count);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: result word differs", $realtime);
                    $display("  expected st %0d dv %0b h %h p %h ts %h cnt %0d", want.status,
                             want.dispatched, want.handle, want.payload, want.stamp,
                             want.count);
                    $display("  actual   st %0d dv %0b h %h p %h ts %h cnt %0d", got.status,
                             got.dispatched, got.handle, got.payload, got.stamp, got.count);
                end
            end
        endfunction
    endclass

    task_queue_scoreboard sb;
    int unsigned          cycle_count;
    int                   words_sent;
    logic [HANDLE_W-1:0]  handle_pool [8];

    task_queue_and_timer_slot_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_task_handle    (i_task_handle),
        .i_timer_delay    (i_timer_delay),
        .i_task_payload   (i_task_payload),
        .i_current_time   (i_current_time),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_dispatch_valid (o_dispatch_valid),
        .o_out_handle     (o_out_handle),
        .o_out_payload    (o_out_payload),
        .o_out_stamp      (o_out_stamp),
        .o_queued_count   (o_queued_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_task_result got;
        if (i_rst_n && o_done === 1'b1) begin
            got.status     = t_status'(o_status);
            got.dispatched = o_dispatch_valid;
            got.handle     = o_out_handle;
            got.payload    = o_out_payload;
            got.stamp      = o_out_stamp;
            got.count      = o_queued_count;
            sb.check_result(got);
        end
    end

    // A command word is taken at the first rising edge with start high and busy low.
    // Start is left high afterwards; a drain, or a next call with a nonzero gap, lowers it.
    task automatic send_command(t_op op, logic [HANDLE_W-1:0] handle,
                                logic [DELAY_W-1:0] delay, logic [DATA_W-1:0] payload,
                                logic [DATA_W-1:0] now, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_operation    = op;
        i_task_handle  = handle;
        i_timer_delay  = delay;
        i_task_payload = payload;
        i_current_time = now;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(op, handle, delay, payload, now);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_null_handle(logic [HANDLE_W-1:0] value);
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_null_handle(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        return ($urandom_range(0, 99) < 85) ? handle_pool[$urandom_range(0, 7)] : $urandom;
    endfunction

    function automatic logic [DELAY_W-1:0] draw_delay();
        logic [DELAY_W-1:0] d;
        case ($urandom_range(0, 4))
            0:       d = 1;
            1:       d = '1;
            default: d = $urandom;
        endcase
        if (d == '0) d = 1;
        return d;
    endfunction

    // Modes: 0 fills the queue toward full, 1 drains it, 2 mixes everything.
    task automatic random_phase(int length);
        int                  mode;
        int                  roll;
        int                  gap;
        int                  th_sched;
        int                  th_timer;
        int                  th_disp;
        int                  th_purge;
        bit                  burst;
        t_op                 op;
        logic [HANDLE_W-1:0] h;
        logic [DELAY_W-1:0]  d;
        mode  = $urandom_range(0, 2);
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 9))
                0:       handle_pool[i] = '0;
                1:       handle_pool[i] = '1;
                default: handle_pool[i] = $urandom;
            endcase
        end
        case (mode)
            0: begin th_sched = 65; th_timer = 75; th_disp = 88; th_purge = 97; end
            1: begin th_sched = 20; th_timer = 30; th_disp = 85; th_purge = 97; end
            default: begin th_sched = 38; th_timer = 55; th_disp = 80; th_purge = 97; end
        endcase
        for (int n = 0; n < length; n++) begin
            roll = $urandom_range(0, 99);
            h    = pick_handle();
            d    = $urandom;
            if (roll < th_sched) begin
                op = OP_SCHEDULE;
                d  = '0;
            end else if (roll < th_timer) begin
                op = OP_SCHEDULE;
                d  = draw_delay();
            end else if (roll < th_disp) begin
                op = OP_DISPATCH;
            end else if (roll < th_purge) begin
                op = OP_PURGE;
                if ($urandom_range(0, 9) == 0) h = sb.null_handle;
            end else begin
                op = OP_NONE;
            end
            gap = burst ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 199) == 0) drain_results();
            send_command(op, h, d, {$urandom, $urandom}, {$urandom, $urandom}, gap);
        end
    endtask

    initial begin
        int phase_no;
        sb             = new();
        cycle_count    = 0;
        words_sent     = 0;
        phase_no       = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_NONE;
        i_task_handle  = '0;
        i_timer_delay  = '0;
        i_task_payload = '0;
        i_current_time = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with the null handle still at its reset value.
        send_command(OP_DISPATCH, '0, '0, '0, '0, 0);
        send_command(OP_NONE, '1, '1, '1, '1, 1);
        send_command(OP_SCHEDULE, '0, '0, '0, '0, 0);
        send_command(OP_SCHEDULE, '1, '0, '1, '1, 2);
        send_command(OP_SCHEDULE, 32'hA5A5_A5A5, '0, 64'h0123_4567_89AB_CDEF,
                     64'hFEDC_BA98_7654_3210, 0);
        // Fill every timer slot, one of them with the same handle as a queued task.
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            send_command(OP_SCHEDULE, (k == 3) ? 32'hA5A5_A5A5 : 32'h100 + k,
                         (k == 0) ? 32'd1 : (k == TIMER_SLOTS - 1) ? '1 : 32'(k * 1000),
                         {$urandom, $urandom}, {$urandom, $urandom}, k % 3);
        end
        send_command(OP_SCHEDULE, 32'h200, 32'd5, {$urandom, $urandom}, '1, 0);
        send_command(OP_PURGE, 32'hA5A5_A5A5, $urandom, '0, '0, 1);
        send_command(OP_SCHEDULE, 32'h201, 32'd7, {$urandom, $urandom}, '0, 0);
        send_command(OP_PURGE, 32'h7777_7777, '0, '1, '1, 0);
        repeat (4) send_command(OP_DISPATCH, $urandom, $urandom, '0, '0, 0);

        // The pause before each register write leaves the engine with nothing pending.
        write_null_handle('1);
        while (words_sent < TARGET_WORDS) begin
            random_phase($urandom_range(40, 120));
            case (phase_no % 4)
                0:       write_null_handle('0);
                1:       write_null_handle($urandom);
                2:       write_null_handle(handle_pool[$urandom_range(0, 7)]);
                default: write_null_handle('1);
            endcase
            phase_no++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
